@@ src/adaptive_penalty_controller_unit_defines.svh @@
`ifndef ADAPTIVE_PENALTY_CONTROLLER_UNIT_DEFINES_SVH
`define ADAPTIVE_PENALTY_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define APC_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define APC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/apc_pkg.sv @@
`timescale 1ns / 1ps

package apc_pkg;

  localparam int NUM_LANES = 3;
  localparam int TGT_W     = 17;
  localparam int PEN_W     = 26;
  localparam int DATA_W    = 32;
  localparam int COST_W    = 48;
  localparam int FRAC_SH   = 16;
  localparam int PROD_W    = PEN_W + DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int TOT_W     = SUM_W + 1;
  localparam int WIDE_W    = 64;

  localparam logic [TGT_W-1:0]  TGT_RESET = 17'd13107;
  localparam logic [PEN_W-1:0]  PEN_RESET = 26'd65536;
  localparam logic [PEN_W-1:0]  PEN_MAX   = 26'd65536000;
  localparam logic [PEN_W-1:0]  PEN_MIN   = 26'd6554;
  localparam logic [TGT_W-1:0]  BAND      = 17'd3277;
  localparam logic [15:0]       RND_BIAS  = 16'h8000;
  localparam logic [COST_W-1:0] COST_MAX  = 48'hFFFF_FFFF_FFFF;

  // p*6/5 rounded = p + (p+2)/5 ; /5 by reciprocal, exact below 2^27
  localparam logic [1:0]  UP_BIAS  = 2'd2;
  localparam logic [26:0] UP_RECIP = 27'd107374183;
  localparam int          UP_SH    = 29;
  // p*17/20 rounded = ((17p+10)>>2)/5 ; reciprocal exact below 2^30
  localparam logic [3:0]  DN_BIAS  = 4'd10;
  localparam logic [28:0] DN_RECIP = 29'd429496730;
  localparam int          DN_SH    = 31;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_ADJUST = 2'd1,
    FUNC_EVAL   = 2'd2
  } apc_func_t;

  typedef enum logic [1:0] {
    REG_TARGET    = 2'd0,
    REG_INIT_LOAD = 2'd1,
    REG_INIT_DUR  = 2'd2,
    REG_INIT_PACK = 2'd3
  } apc_reg_t;

  typedef struct packed {
    logic              en;
    apc_reg_t          idx;
    logic [DATA_W-1:0] data;
  } apc_cfg_wr_t;

endpackage

@@ src/adaptive_penalty_controller_unit.sv @@
// Pipeline: a beat accepted into the s1 registers moves through the s2, s3 and
// output registers; one beat per cycle while out_ready holds, and an adjust right
// after an adjust waits for the penalty quotient registers to refresh.
// Reset (rst_n, synchronous): windows read as all ones, counts at the window
// length, pointer zero, penalties and config registers at their reset values.
`timescale 1ns / 1ps
`include "adaptive_penalty_controller_unit_defines.svh"

module adaptive_penalty_controller_unit import apc_pkg::*; #(
  parameter int WINDOW_LENGTH = 100
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic                in_load_ok,
  input  logic                in_duration_ok,
  input  logic                in_pack_ok,
  input  logic [DATA_W-1:0]   in_route_distance,
  input  logic [DATA_W-1:0]   in_load_excess,
  input  logic [DATA_W-1:0]   in_duration_excess,
  input  logic [DATA_W-1:0]   in_pack_excess,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [COST_W-1:0]   out_penalized_cost,
  output logic [PEN_W-1:0]    out_load_penalty,
  output logic [PEN_W-1:0]    out_duration_penalty,
  output logic [PEN_W-1:0]    out_pack_penalty,
  output logic                out_cost_saturated
);

  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

  apc_cfg_wr_t       cfg_wr;
  logic              in_acc;
  logic              push;

  logic              s1_v_r;
  apc_func_t         s1_func_r;
  logic [DATA_W-1:0] s1_dist_r;
  logic [DATA_W-1:0] s1_exc_r [NUM_LANES];
  logic              s1_record;
  logic              s1_adjust;
  logic              s1_go;
  logic              s1_ready;
  logic              s1_block;

  logic              s2_v_r;
  logic              s2_eval_r;
  logic [DATA_W-1:0] s2_dist_r;
  logic [PROD_W-1:0] s2_prod_r [NUM_LANES];
  logic [PEN_W-1:0]  s2_pen_r  [NUM_LANES];
  logic              s2_go;
  logic              s2_ready;

  logic              s3_v_r;
  logic              s3_eval_r;
  logic [SUM_W-1:0]  s3_sum_a_r;
  logic [SUM_W-1:0]  s3_sum_b_r;
  logic [PEN_W-1:0]  s3_pen_r [NUM_LANES];
  logic              s3_go;
  logic              s3_ready;

  logic              out_v_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_sat_r;
  logic [PEN_W-1:0]  out_pen_r [NUM_LANES];
  logic              s4_ready;

  logic [CNT_W-1:0]  count    [NUM_LANES];
  logic [PEN_W-1:0]  pen      [NUM_LANES];
  logic [PEN_W-1:0]  pen_next [NUM_LANES];
  logic              stale;
  logic [PROD_W-1:0] prod     [NUM_LANES];
  logic [TOT_W-1:0]  total;
  logic [WIDE_W-1:0] cost_wide;
  logic              cost_sat;
  logic [COST_W-1:0] cost_val;

  // config port
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = apc_reg_t'(paddr[3:2]);
  assign cfg_wr.data = pwdata;
  assign pready      = 1'b1;

  // stage handshake
  assign s4_ready  = !out_v_r || out_ready;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s3_go     = s3_v_r && s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s2_go     = s2_v_r && s3_ready;
  assign s1_record = s1_func_r == FUNC_RECORD;
  assign s1_adjust = s1_func_r == FUNC_ADJUST;
  assign s1_block  = s1_adjust && stale;
  assign s1_go     = s1_v_r && s2_ready && !s1_block;
  assign s1_ready  = !s1_v_r || s1_go;
  assign in_ready  = s1_ready;
  assign in_acc    = in_valid && s1_ready;
  assign push      = in_acc && (apc_func_t'(in_func) == FUNC_RECORD);

  apc_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .ok_bits ({in_pack_ok, in_duration_ok, in_load_ok}),
    .commit  (s1_go && s1_record),
    .count   (count)
  );

  apc_penalty #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_penalty (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_wr),
    .rd_idx     (apc_reg_t'(paddr[3:2])),
    .rd_data    (prdata),
    .adj_commit (s1_go && s1_adjust),
    .count      (count),
    .pen        (pen),
    .pen_next   (pen_next),
    .stale      (stale)
  );

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod[i] = PROD_W'(pen[i]) * PROD_W'(s1_exc_r[i]);
    end
  end

  assign total     = TOT_W'(s3_sum_a_r) + TOT_W'(s3_sum_b_r);
  assign cost_wide = WIDE_W'(total[TOT_W-1:FRAC_SH]);
  assign cost_sat  = cost_wide > WIDE_W'(COST_MAX);
  assign cost_val  = cost_sat ? COST_MAX : cost_wide[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_go;
      end
      if (s3_ready) begin
        s3_v_r <= s2_go;
      end
      if (s4_ready) begin
        out_v_r <= s3_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r   <= apc_func_t'(in_func);
      s1_dist_r   <= in_route_distance;
      s1_exc_r[0] <= in_load_excess;
      s1_exc_r[1] <= in_duration_excess;
      s1_exc_r[2] <= in_pack_excess;
    end
    if (s1_go) begin
      s2_eval_r <= s1_func_r == FUNC_EVAL;
      s2_dist_r <= s1_dist_r;
      s2_prod_r <= prod;
      s2_pen_r  <= pen_next;
    end
    if (s2_go) begin
      s3_eval_r  <= s2_eval_r;
      s3_sum_a_r <= SUM_W'(s2_prod_r[0]) + SUM_W'(s2_prod_r[1]);
      s3_sum_b_r <= SUM_W'(s2_prod_r[2]) + SUM_W'({s2_dist_r, RND_BIAS});
      s3_pen_r   <= s2_pen_r;
    end
    if (s3_go) begin
      out_cost_r <= s3_eval_r ? cost_val : '0;
      out_sat_r  <= s3_eval_r && cost_sat;
      out_pen_r  <= s3_pen_r;
    end
  end

  assign out_valid            = out_v_r;
  assign out_penalized_cost   = out_cost_r;
  assign out_cost_saturated   = out_sat_r;
  assign out_load_penalty     = out_pen_r[0];
  assign out_duration_penalty = out_pen_r[1];
  assign out_pack_penalty     = out_pen_r[2];

  `APC_ASSERT_NEXT(a_adj_interlock, s1_go && s1_adjust, !(s1_go && s1_adjust), "adjust on stale quotients")
  `APC_ASSERT_NEXT(a_count_hold, !(s1_go && s1_record) && !push, $stable(count[0]), "load count moved without record")
  `APC_ASSERT_NOW(a_stall_in, s1_v_r && !s2_ready, !in_ready, "beat taken into a full stage")
  `APC_ASSERT_NEXT(a_pen_range, s1_go && s1_adjust, (pen[0] >= PEN_MIN) && (pen[0] <= PEN_MAX), "load penalty out of range")

endmodule

@@ src/apc_ram.sv @@
`timescale 1ns / 1ps

module apc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 100,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/apc_window.sv @@
`timescale 1ns / 1ps

module apc_window import apc_pkg::*; #(
  parameter int WINDOW_LENGTH = 100,
  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1),
  localparam int PTR_W = $clog2(WINDOW_LENGTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [NUM_LANES-1:0] ok_bits,
  input  logic                 commit,
  output logic [CNT_W-1:0]     count [NUM_LANES]
);

  localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW_LENGTH - 1);

  logic [PTR_W-1:0]     ptr_r;
  logic [PTR_W-1:0]     ptr_nxt;
  logic                 wrap_r;
  logic                 fresh_r;
  logic [NUM_LANES-1:0] bits_r;
  logic [NUM_LANES-1:0] old_bits;
  logic [NUM_LANES-1:0] rd_data;
  logic [CNT_W-1:0]     cnt_r   [NUM_LANES];
  logic [CNT_W-1:0]     cnt_nxt [NUM_LANES];

  apc_ram #(
    .WIDTH (NUM_LANES),
    .DEPTH (WINDOW_LENGTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (ptr_r),
    .wr_data (ok_bits),
    .rd_en   (push),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  assign ptr_nxt = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;

  // entries not yet written since reset hold ones
  assign old_bits = fresh_r ? '1 : rd_data;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (bits_r[i] && !old_bits[i]) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end else if (!bits_r[i] && old_bits[i]) begin
        cnt_nxt[i] = cnt_r[i] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      wrap_r <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        cnt_r[i] <= CNT_W'(WINDOW_LENGTH);
      end
    end else begin
      if (push) begin
        ptr_r <= ptr_nxt;
        if (ptr_r == LAST) begin
          wrap_r <= 1'b1;
        end
      end
      if (commit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      bits_r  <= ok_bits;
      fresh_r <= !wrap_r;
    end
  end

  assign count = cnt_r;

endmodule

@@ src/apc_penalty.sv @@
`timescale 1ns / 1ps

module apc_penalty import apc_pkg::*; #(
  parameter int WINDOW_LENGTH = 100,
  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  apc_cfg_wr_t       cfg,
  input  apc_reg_t          rd_idx,
  output logic [DATA_W-1:0] rd_data,
  input  logic              adj_commit,
  input  logic [CNT_W-1:0]  count    [NUM_LANES],
  output logic [PEN_W-1:0]  pen      [NUM_LANES],
  output logic [PEN_W-1:0]  pen_next [NUM_LANES],
  output logic              stale
);

  localparam int TP_W      = TGT_W + 1;
  localparam int BND_W     = TP_W + CNT_W;
  localparam int SCL_W     = CNT_W + 16;
  localparam int UPY_W     = PEN_W + 1;
  localparam int UPP_W     = UPY_W + 27;
  localparam int DNZ_W     = PEN_W + 5;
  localparam int DNW_W     = DNZ_W - 2;
  localparam int DNP_W     = DNW_W + 29;
  localparam logic [BND_W-1:0] HI_RESET =
    BND_W'((int'(TGT_RESET) + int'(BAND)) * WINDOW_LENGTH);
  localparam logic [BND_W-1:0] LO_RESET =
    BND_W'((int'(TGT_RESET) - int'(BAND)) * WINDOW_LENGTH);

  logic [TGT_W-1:0]     target_r;
  logic [PEN_W-1:0]     init_r  [NUM_LANES];
  logic [PEN_W-1:0]     pen_r   [NUM_LANES];
  logic [PEN_W-1:0]     pen_nxt [NUM_LANES];
  logic [PEN_W-1:0]     q_up_r  [NUM_LANES];
  logic [PEN_W-1:0]     q_dn_r  [NUM_LANES];
  logic [BND_W-1:0]     lo_r;
  logic [BND_W-1:0]     hi_r;
  logic                 lo_pos_r;
  logic                 stale_r;
  logic [TGT_W-1:0]     wr_tgt;
  logic [TP_W-1:0]      wr_tp;
  logic [TP_W-1:0]      wr_tm;
  logic [PEN_W-1:0]     wr_pen;
  logic [PEN_W-1:0]     wr_pen_clamped;
  logic [NUM_LANES-1:0] wr_lane;
  logic                 wr_tgt_en;
  logic [UPY_W-1:0]     up_y    [NUM_LANES];
  logic [UPP_W-1:0]     up_prod [NUM_LANES];
  logic [DNZ_W-1:0]     dn_z    [NUM_LANES];
  logic [DNP_W-1:0]     dn_prod [NUM_LANES];
  logic [UPY_W-1:0]     up_sum  [NUM_LANES];
  logic [PEN_W-1:0]     up_val  [NUM_LANES];
  logic [PEN_W-1:0]     dn_val  [NUM_LANES];
  logic [BND_W-1:0]     scaled  [NUM_LANES];
  logic [NUM_LANES-1:0] below;
  logic [NUM_LANES-1:0] above;

  assign wr_tgt = cfg.data[TGT_W-1:0];
  assign wr_tp  = TP_W'(wr_tgt) + TP_W'(BAND);
  assign wr_tm  = TP_W'(wr_tgt) - TP_W'(BAND);
  assign wr_pen = cfg.data[PEN_W-1:0];

  always_comb begin
    wr_pen_clamped = wr_pen;
    if (wr_pen < PEN_MIN) begin
      wr_pen_clamped = PEN_MIN;
    end else if (wr_pen > PEN_MAX) begin
      wr_pen_clamped = PEN_MAX;
    end
  end

  always_comb begin
    wr_lane   = '0;
    wr_tgt_en = 1'b0;
    case (cfg.idx)
      REG_TARGET:    wr_tgt_en  = cfg.en;
      REG_INIT_LOAD: wr_lane[0] = cfg.en;
      REG_INIT_DUR:  wr_lane[1] = cfg.en;
      REG_INIT_PACK: wr_lane[2] = cfg.en;
      default:       wr_lane    = '0;
    endcase
  end

  // quotient candidates, registered from the current pen_r
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      up_y[i]    = UPY_W'(pen_r[i]) + UPY_W'(UP_BIAS);
      up_prod[i] = UPP_W'(up_y[i]) * UPP_W'(UP_RECIP);
      dn_z[i]    = (DNZ_W'(pen_r[i]) << 4) + DNZ_W'(pen_r[i]) + DNZ_W'(DN_BIAS);
      dn_prod[i] = DNP_W'(dn_z[i][DNZ_W-1:2]) * DNP_W'(DN_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      q_up_r[i] <= PEN_W'(up_prod[i][UPP_W-1:UP_SH]);
      q_dn_r[i] <= PEN_W'(dn_prod[i][DNP_W-1:DN_SH]);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      scaled[i] = BND_W'({count[i], 16'd0});
      below[i]  = lo_pos_r && (scaled[i] < lo_r);
      above[i]  = scaled[i] > hi_r;
      up_sum[i] = UPY_W'(pen_r[i]) + UPY_W'(q_up_r[i]);
      up_val[i] = (up_sum[i] > UPY_W'(PEN_MAX)) ? PEN_MAX : up_sum[i][PEN_W-1:0];
      dn_val[i] = (q_dn_r[i] < PEN_MIN) ? PEN_MIN : q_dn_r[i];
      pen_nxt[i] = pen_r[i];
      if (wr_lane[i]) begin
        pen_nxt[i] = wr_pen_clamped;
      end else if (adj_commit) begin
        if (below[i] && (pen_r[i] < PEN_MAX)) begin
          pen_nxt[i] = up_val[i];
        end else if (above[i] && (pen_r[i] > PEN_MIN)) begin
          pen_nxt[i] = dn_val[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TGT_RESET;
      hi_r     <= HI_RESET;
      lo_r     <= LO_RESET;
      lo_pos_r <= 1'b1;
      stale_r  <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        init_r[i] <= PEN_RESET;
        pen_r[i]  <= PEN_RESET;
      end
    end else begin
      pen_r   <= pen_nxt;
      stale_r <= adj_commit || (|wr_lane);
      if (wr_tgt_en) begin
        target_r <= wr_tgt;
        hi_r     <= BND_W'(wr_tp) * BND_W'(WINDOW_LENGTH);
        lo_r     <= BND_W'(wr_tm) * BND_W'(WINDOW_LENGTH);
        lo_pos_r <= wr_tgt >= BAND;
      end
      for (int i = 0; i < NUM_LANES; i++) begin
        if (wr_lane[i]) begin
          init_r[i] <= wr_pen;
        end
      end
    end
  end

  always_comb begin
    case (rd_idx)
      REG_TARGET:    rd_data = DATA_W'(target_r);
      REG_INIT_LOAD: rd_data = DATA_W'(init_r[0]);
      REG_INIT_DUR:  rd_data = DATA_W'(init_r[1]);
      REG_INIT_PACK: rd_data = DATA_W'(init_r[2]);
      default:       rd_data = '0;
    endcase
  end

  assign pen      = pen_r;
  assign pen_next = pen_nxt;
  assign stale    = stale_r;

endmodule
